// ===== rtl/one_wire_rom_search_unit_macros.svh =====
// ----------------------------------------------------------------------------
// One-wire ROM search unit - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_ROM_SEARCH_UNIT_MACROS_SVH
`define ONE_WIRE_ROM_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define OWS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ows_pkg.sv =====
// ----------------------------------------------------------------------------
// ows_pkg
// Types, codes and the CRC-8 helper for the one-wire ROM search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ows_pkg;

    localparam int ID_BYTES_DEF = 8;
    localparam int FAMILY_LIMIT = 9;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef enum logic [1:0] {
        FN_FIRST    = 2'd0,
        FN_NEXT     = 2'd1,
        FN_PRESENCE = 2'd2,
        FN_BITS     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        K_AWAIT     = 3'd0,
        K_COMMAND   = 3'd1,
        K_DIRECTION = 3'd2,
        K_FINISHED  = 3'd3,
        K_IGNORED   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_SEARCH = 2'd2
    } phase_t;

    typedef struct packed {
        func_t func;
        logic  presence;
        logic  id_bit;
        logic  complement_bit;
    } ows_item_t;

    typedef struct packed {
        kind_t      kind;
        logic       dir_bit;
        logic       found;
        logic [3:0] family_branch;
        logic       last_device;
    } ows_flags_t;

    // Dallas CRC-8, reflected, one byte
    function automatic logic [7:0] ows_crc8(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       mix;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ data[i];
            c   = c >> 1;
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ows_engine.sv =====
// ----------------------------------------------------------------------------
// ows_engine
// Search state and combinational decision logic for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ows_engine
    import ows_pkg::*;
#(
    parameter int ID_BYTES = ID_BYTES_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire ows_item_t               item,
    output ows_flags_t                   flags,
    output logic [ID_BYTES*8-1:0]        device_id
);

    localparam int ID_BITS = ID_BYTES * 8;
    localparam int POS_W   = $clog2(ID_BITS + 2);
    localparam int IDX_W   = $clog2(ID_BITS);

    logic [ID_BITS-1:0] id_store_reg,      id_store_next;
    logic [POS_W-1:0]   branch_point_reg,  branch_point_next;
    logic [3:0]         family_branch_reg, family_branch_next;
    logic               done_mark_reg,     done_mark_next;
    logic [POS_W-1:0]   bit_position_reg,  bit_position_next;
    logic [POS_W-1:0]   newest_zero_reg,   newest_zero_next;
    logic [7:0]         crc_acc_reg,       crc_acc_next;
    phase_t             phase_reg,         phase_next;

    // search datapath for a bit pair
    logic [IDX_W-1:0]   idx;
    logic [ID_BITS-1:0] mask;
    logic               dir;
    logic               zero_taken;
    logic [ID_BITS-1:0] id_upd;
    logic [7:0]         byte_sel;
    logic [7:0]         crc_upd;
    logic [POS_W-1:0]   newest_upd;
    logic [3:0]         family_upd;
    logic               last_bit;
    logic               crc_ok;

    always_comb
    begin
        idx  = IDX_W'(bit_position_reg - POS_W'(1));
        mask = {{(ID_BITS-1){1'b0}}, 1'b1} << idx;
        if (item.id_bit != item.complement_bit)
        begin
            dir = item.id_bit;
        end
        else if (bit_position_reg < branch_point_reg)
        begin
            dir = id_store_reg[idx];
        end
        else
        begin
            dir = (bit_position_reg == branch_point_reg);
        end
        zero_taken = (item.id_bit == item.complement_bit) && !dir;
        id_upd     = dir ? (id_store_reg | mask) : (id_store_reg & ~mask);
        byte_sel   = id_upd[{idx[IDX_W-1:3], 3'b000} +: 8];
        crc_upd    = (idx[2:0] == 3'b111) ? ows_crc8(crc_acc_reg, byte_sel) : crc_acc_reg;
        newest_upd = zero_taken ? bit_position_reg : newest_zero_reg;
        family_upd = (zero_taken && (bit_position_reg < POS_W'(FAMILY_LIMIT)))
                     ? bit_position_reg[3:0] : family_branch_reg;
        last_bit   = (bit_position_reg == POS_W'(ID_BITS));
        crc_ok     = (crc_upd == 8'h00);
    end

    always_comb
    begin
        id_store_next      = id_store_reg;
        branch_point_next  = branch_point_reg;
        family_branch_next = family_branch_reg;
        done_mark_next     = done_mark_reg;
        bit_position_next  = bit_position_reg;
        newest_zero_next   = newest_zero_reg;
        crc_acc_next       = crc_acc_reg;
        phase_next         = phase_reg;
        flags.kind         = K_IGNORED;
        flags.dir_bit      = 1'b0;
        flags.found        = 1'b0;

        case (item.func)
            FN_FIRST, FN_NEXT:
            begin
                if (item.func == FN_FIRST)
                begin
                    id_store_next = '0;
                end
                // only a next search checks the done mark; a first search wipes it
                if (item.func == FN_NEXT && done_mark_reg)
                begin
                    branch_point_next  = '0;
                    family_branch_next = '0;
                    done_mark_next     = 1'b0;
                    phase_next         = PH_IDLE;
                    flags.kind         = K_FINISHED;
                end
                else
                begin
                    if (item.func == FN_FIRST)
                    begin
                        branch_point_next  = '0;
                        family_branch_next = '0;
                        done_mark_next     = 1'b0;
                    end
                    phase_next        = PH_WAIT;
                    bit_position_next = POS_W'(1);
                    newest_zero_next  = '0;
                    crc_acc_next      = '0;
                    flags.kind        = K_AWAIT;
                end
            end
            FN_PRESENCE:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (item.presence)
                    begin
                        phase_next = PH_SEARCH;
                        flags.kind = K_COMMAND;
                    end
                    else
                    begin
                        branch_point_next  = '0;
                        family_branch_next = '0;
                        done_mark_next     = 1'b0;
                        phase_next         = PH_IDLE;
                        flags.kind         = K_FINISHED;
                    end
                end
            end
            FN_BITS:
            begin
                if (phase_reg == PH_SEARCH)
                begin
                    if (item.id_bit && item.complement_bit)
                    begin
                        branch_point_next  = '0;
                        family_branch_next = '0;
                        done_mark_next     = 1'b0;
                        phase_next         = PH_IDLE;
                        flags.kind         = K_FINISHED;
                    end
                    else
                    begin
                        flags.dir_bit      = dir;
                        id_store_next      = id_upd;
                        newest_zero_next   = newest_upd;
                        family_branch_next = family_upd;
                        bit_position_next  = bit_position_reg + POS_W'(1);
                        crc_acc_next       = crc_upd;
                        if (last_bit)
                        begin
                            if (crc_ok)
                            begin
                                branch_point_next = newest_upd;
                                if (newest_upd == '0)
                                begin
                                    done_mark_next = 1'b1;
                                end
                            end
                            // bad CRC or zero family code: failure
                            if (!crc_ok || id_upd[7:0] == 8'h00)
                            begin
                                branch_point_next  = '0;
                                family_branch_next = '0;
                                done_mark_next     = 1'b0;
                            end
                            else
                            begin
                                flags.found = 1'b1;
                            end
                            phase_next = PH_IDLE;
                            flags.kind = K_FINISHED;
                        end
                        else
                        begin
                            flags.kind = K_DIRECTION;
                        end
                    end
                end
            end
            default:
            begin
                flags.kind = K_IGNORED;
            end
        endcase

        flags.family_branch = family_branch_next;
        flags.last_device   = done_mark_next;
        device_id           = id_store_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_store_reg      <= '0;
            branch_point_reg  <= '0;
            family_branch_reg <= '0;
            done_mark_reg     <= 1'b0;
            bit_position_reg  <= POS_W'(1);
            newest_zero_reg   <= '0;
            crc_acc_reg       <= '0;
            phase_reg         <= PH_IDLE;
        end
        else if (step)
        begin
            id_store_reg      <= id_store_next;
            branch_point_reg  <= branch_point_next;
            family_branch_reg <= family_branch_next;
            done_mark_reg     <= done_mark_next;
            bit_position_reg  <= bit_position_next;
            newest_zero_reg   <= newest_zero_next;
            crc_acc_reg       <= crc_acc_next;
            phase_reg         <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/one_wire_rom_search_unit.sv =====
// Items pass the input register, then the result register, one per cycle unless
// m_axis_tready stalls; a new item is taken while a result waits to be taken.
// The search state is updated in the single cycle an item moves to the result register.
// Reset (rst_n low, asynchronous) clears both stage valids and all search state;
// bit position returns to 1 and the phase to idle.
// ----------------------------------------------------------------------------
// one_wire_rom_search_unit
// Search ROM decision engine: registered input stage, decision, result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "one_wire_rom_search_unit_macros.svh"

module one_wire_rom_search_unit
    import ows_pkg::*;
#(
    parameter int ID_BYTES = ID_BYTES_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // [0] presence, [1] id_bit, [2] complement_bit, [7:3] zero
    input  wire logic [7:0]                             s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]                             s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // [0] dir_bit, [1] found, [ID+1:2] device_id, [ID+5:ID+2] family_branch_out,
    // [ID+6] last_device, rest zero
    output logic [((ID_BYTES*8+7+7)/8)*8-1:0]           m_axis_tdata,
    // [2:0] kind
    output logic [2:0]                                  m_axis_tuser
);

    localparam int ID_BITS    = ID_BYTES * 8;
    localparam int OUT_DATA_W = ((ID_BITS + 7 + 7) / 8) * 8;

    logic               in_valid_reg;
    ows_item_t          in_item_reg;
    logic               out_valid_reg;
    ows_flags_t         out_flags_reg;
    logic [ID_BITS-1:0] out_id_reg;

    logic               out_free;
    logic               step;
    ows_flags_t         eng_flags;
    logic [ID_BITS-1:0] eng_id;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    ows_engine #(
        .ID_BYTES (ID_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_item_reg),
        .flags     (eng_flags),
        .device_id (eng_id)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.func           <= func_t'(s_axis_tuser);
            in_item_reg.presence       <= s_axis_tdata[0];
            in_item_reg.id_bit         <= s_axis_tdata[1];
            in_item_reg.complement_bit <= s_axis_tdata[2];
        end
        if (step)
        begin
            out_flags_reg <= eng_flags;
            out_id_reg    <= eng_id;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_flags_reg.kind;
    assign m_axis_tdata  = OUT_DATA_W'({out_flags_reg.last_device, out_flags_reg.family_branch,
                                        out_id_reg, out_flags_reg.found,
                                        out_flags_reg.dir_bit});

    `OWS_ASSERT_IMPLIES(a_found_only_finished,
        m_axis_tvalid && out_flags_reg.found,
        out_flags_reg.kind == K_FINISHED,
        "found set on a result that does not end a pass")
    `OWS_ASSERT_IMPLIES(a_dir_only_bits,
        m_axis_tvalid && out_flags_reg.dir_bit,
        out_flags_reg.kind == K_DIRECTION || out_flags_reg.kind == K_FINISHED,
        "direction bit on a result with no bit decision")
    `OWS_ASSERT_IMPLIES(a_stall_only_full,
        !s_axis_tready,
        in_valid_reg && out_valid_reg && !m_axis_tready,
        "input stalled while a stage is free")
    `OWS_ASSERT_NEXT(a_step_gives_result,
        step,
        out_valid_reg,
        "decided item did not reach the result register")

endmodule

`default_nettype wire
